// ----- rtl/assert_macros.svh -----
// Assertion macros used by the port checker file.
// Depends on nothing; included by the checker module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Clocked implication with active-low reset disable.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Same, checked also during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`endif

// ----- rtl/rmq_pkg.sv -----
// Shared types and constants for the rotation matrix to quaternion unit.
// No dependencies.
package rmq_pkg;
  localparam int FRAC_BITS_DEF = 14;
  localparam int ELEM_W = 16;
  localparam int Q_W = 16;

  typedef enum logic [1:0] {
    BR_TRACE = 2'd0,
    BR_X     = 2'd1,
    BR_Y     = 2'd2,
    BR_Z     = 2'd3
  } branch_t;
endpackage

// ----- rtl/rmq_sqrt.sv -----
// Pipelined integer square root, one result bit per stage.
// Depends on rmq_pkg; used by the top level.
module rmq_sqrt import rmq_pkg::*; #(
  parameter int IN_W = 36,
  parameter int SIDE_W = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  in_vld,
  input  logic [IN_W-1:0]       in_rad,
  input  logic [SIDE_W-1:0]     in_side,
  output logic                  out_vld,
  output logic [IN_W/2-1:0]     out_root,
  output logic [SIDE_W-1:0]     out_side
);
  localparam int N = IN_W / 2;
  // The remainder never exceeds twice the partial root, so N+1 bits hold it.
  localparam int REM_W = N + 1;

  // Register set k holds the state after stage k has retired root bit N-1-k
  // (restoring method on two radicand bits).
  logic [N-1:0]      vld_r;
  logic [IN_W-1:0]   rad_r  [N];
  logic [REM_W-1:0]  rem_r  [N];
  logic [N-1:0]      root_r [N];
  logic [SIDE_W-1:0] side_r [N];

  // Stage inputs: the ports for the first stage, the previous registers after.
  logic              st_vld  [N];
  logic [IN_W-1:0]   st_rad  [N];
  logic [REM_W-1:0]  st_rem  [N];
  logic [N-1:0]      st_root [N];
  logic [SIDE_W-1:0] st_side [N];
  logic [REM_W+1:0]  cur     [N];
  logic [REM_W+1:0]  trial   [N];

  always_comb begin
    for (int k = 0; k < N; k++) begin
      if (k == 0) begin
        st_vld[k] = in_vld;
        st_rad[k] = in_rad;
        st_rem[k] = '0;
        st_root[k] = '0;
        st_side[k] = in_side;
      end else begin
        st_vld[k] = vld_r[k-1];
        st_rad[k] = rad_r[k-1];
        st_rem[k] = rem_r[k-1];
        st_root[k] = root_r[k-1];
        st_side[k] = side_r[k-1];
      end
      cur[k] = {st_rem[k], st_rad[k][IN_W-1 -: 2]};
      trial[k] = {1'b0, st_root[k], 2'b01};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      for (int k = 0; k < N; k++) vld_r[k] <= st_vld[k];
    end
    if (en) begin
      for (int k = 0; k < N; k++) begin
        rad_r[k] <= {st_rad[k][IN_W-3:0], 2'b00};
        side_r[k] <= st_side[k];
        if (cur[k] >= trial[k]) begin
          rem_r[k] <= REM_W'(cur[k] - trial[k]);
          root_r[k] <= {st_root[k][N-2:0], 1'b1};
        end else begin
          rem_r[k] <= REM_W'(cur[k]);
          root_r[k] <= {st_root[k][N-2:0], 1'b0};
        end
      end
    end
  end

  assign out_vld = vld_r[N-1];
  assign out_root = root_r[N-1];
  assign out_side = side_r[N-1];
endmodule

// ----- rtl/rmq_div.sv -----
// Pipelined restoring divider for three magnitudes sharing one divisor.
// Depends on rmq_pkg; the quotient is NUM_W bits wide and is not saturated.
module rmq_div import rmq_pkg::*; #(
  parameter int NUM_W = 32,
  parameter int DEN_W = 18,
  parameter int SIDE_W = 8
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 en,
  input  logic                 in_vld,
  input  logic [NUM_W-1:0]     in_num [3],
  input  logic [DEN_W-1:0]     in_den,
  input  logic [SIDE_W-1:0]    in_side,
  output logic                 out_vld,
  output logic [NUM_W-1:0]     out_quo [3],
  output logic [SIDE_W-1:0]    out_side
);
  // One quotient bit per stage, MSB first. Register set k is the output of
  // stage k.
  logic [NUM_W-1:0]       vld_r;
  logic [NUM_W-1:0]       num_r [NUM_W][3];
  logic [DEN_W-1:0]       rem_r [NUM_W][3];
  logic [DEN_W-1:0]       den_r [NUM_W];
  logic [SIDE_W-1:0]      side_r [NUM_W];

  // Stage inputs: the ports for the first stage, the previous registers after.
  logic                   st_vld  [NUM_W];
  logic [NUM_W-1:0]       st_num  [NUM_W][3];
  logic [DEN_W-1:0]       st_rem  [NUM_W][3];
  logic [DEN_W-1:0]       st_den  [NUM_W];
  logic [SIDE_W-1:0]      st_side [NUM_W];
  logic [DEN_W:0]         shl     [NUM_W][3];

  always_comb begin
    for (int i = 0; i < NUM_W; i++) begin
      if (i == 0) begin
        st_vld[i] = in_vld;
        st_den[i] = in_den;
        st_side[i] = in_side;
        for (int k = 0; k < 3; k++) begin
          st_num[i][k] = in_num[k];
          st_rem[i][k] = '0;
        end
      end else begin
        st_vld[i] = vld_r[i-1];
        st_den[i] = den_r[i-1];
        st_side[i] = side_r[i-1];
        for (int k = 0; k < 3; k++) begin
          st_num[i][k] = num_r[i-1][k];
          st_rem[i][k] = rem_r[i-1][k];
        end
      end
      // The remainder stays below the divisor, so DEN_W+1 bits hold the shift.
      for (int k = 0; k < 3; k++) shl[i][k] = {st_rem[i][k], st_num[i][k][NUM_W-1]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      for (int i = 0; i < NUM_W; i++) vld_r[i] <= st_vld[i];
    end
    if (en) begin
      for (int i = 0; i < NUM_W; i++) begin
        den_r[i] <= st_den[i];
        side_r[i] <= st_side[i];
        for (int k = 0; k < 3; k++) begin
          if (shl[i][k] >= {1'b0, st_den[i]}) begin
            rem_r[i][k] <= DEN_W'(shl[i][k] - {1'b0, st_den[i]});
            num_r[i][k] <= {st_num[i][k][NUM_W-2:0], 1'b1};
          end else begin
            rem_r[i][k] <= DEN_W'(shl[i][k]);
            num_r[i][k] <= {st_num[i][k][NUM_W-2:0], 1'b0};
          end
        end
      end
    end
  end

  assign out_vld = vld_r[NUM_W-1];
  assign out_side = side_r[NUM_W-1];
  always_comb begin
    for (int k = 0; k < 3; k++) out_quo[k] = num_r[NUM_W-1][k];
  end
endmodule

// ----- rtl/rotation_matrix_to_quaternion_unit.sv -----
// Rotation matrix to quaternion unit, Shepperd branch scheme, fixed point.
// Depends on rmq_pkg, rmq_sqrt and rmq_div.
//
// Usage: one beat on the in_ stream carries a full 3x3 matrix, row-major,
// each element FRAC_BITS fraction bits. One beat comes out on the out_
// stream for every input beat, in order: qx, qy, qz, qw, the branch that
// was chosen and a bad-matrix flag (components zero when set).
// From the accepting edge to out_tvalid a beat passes one register for
// branch choice, one root stage per root bit, one divider stage per
// quotient bit (numerator selection and saturation are folded into
// neighboring stages) and the output register.
// Throughput is one beat per cycle while the output is not stalled: the
// root and the divider are fully pipelined, one bit per stage.
// The whole pipe advances as one; when out_tready is low and the output
// register is full, every stage holds, bubbles included, and in_tready
// falls, so nothing is lost or repeated.
// Reset (synchronous, rst_n low) clears all valid bits; data registers are
// not reset. The block keeps no state between beats.
module rotation_matrix_to_quaternion_unit import rmq_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // m00, m01, m02, m10, m11, m12, m20, m21, m22 from bit 0 up, 16 bits each.
  input  logic [143:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // qx, qy, qz, qw from bit 0 up, 16 bits each.
  output logic [63:0]  out_tdata,
  // branch_used (bits 1:0), bad_matrix (bit 2).
  output logic [2:0]   out_tuser
);
  // Argument up to ONE+3*32768, signed.
  localparam int ARG_W = ((FRAC_BITS > 15) ? FRAC_BITS : 15) + 4;
  localparam int RAD_W0 = ARG_W + FRAC_BITS;
  localparam int RAD_W = RAD_W0 + (RAD_W0 % 2);
  localparam int ROOT_W = RAD_W / 2;
  localparam int NMAG_W = 17;                  // |sum of two elements| <= 65536
  localparam int NUM_W = NMAG_W + FRAC_BITS;
  localparam int DEN_W = ROOT_W + 1;
  localparam logic signed [ARG_W-1:0] ONE_A = ARG_W'(1) <<< FRAC_BITS;
  localparam int SIDE_W = 3 + 3 * 18;          // bad, branch, three numerators

  logic en;
  logic out_vld_r;
  assign en = !out_vld_r || out_tready;
  assign in_tready = en;

  // Stage 1: branch choice and root argument.
  logic signed [ELEM_W-1:0] m [9];
  always_comb begin
    for (int k = 0; k < 9; k++) m[k] = in_tdata[k*ELEM_W +: ELEM_W];
  end

  logic signed [ARG_W-1:0] tr, a1, a2, a3;
  branch_t br_nxt;
  logic signed [ARG_W-1:0] arg_nxt;
  always_comb begin
    tr = ARG_W'(m[0]) + ARG_W'(m[4]) + ARG_W'(m[8]);
    a1 = ONE_A + ARG_W'(m[0]) - ARG_W'(m[4]) - ARG_W'(m[8]);
    a2 = ONE_A + ARG_W'(m[4]) - ARG_W'(m[0]) - ARG_W'(m[8]);
    a3 = ONE_A + ARG_W'(m[8]) - ARG_W'(m[0]) - ARG_W'(m[4]);
    priority if (tr > 0) begin
      br_nxt = BR_TRACE; arg_nxt = ONE_A + tr;
    end else if (m[0] > m[4] && m[0] > m[8]) begin
      br_nxt = BR_X; arg_nxt = a1;
    end else if (m[4] > m[8]) begin
      br_nxt = BR_Y; arg_nxt = a2;
    end else begin
      br_nxt = BR_Z; arg_nxt = a3;
    end
  end

  // Numerators (signed 18 bits), selected per branch: slots a, b, c feed
  // the three quotients; order depends on branch at the output.
  logic signed [17:0] na_nxt, nb_nxt, nc_nxt;
  always_comb begin
    unique case (br_nxt)
      BR_TRACE: begin
        na_nxt = 18'(m[7]) - 18'(m[5]); nb_nxt = 18'(m[2]) - 18'(m[6]);
        nc_nxt = 18'(m[3]) - 18'(m[1]);
      end
      BR_X: begin
        na_nxt = 18'(m[1]) + 18'(m[3]); nb_nxt = 18'(m[2]) + 18'(m[6]);
        nc_nxt = 18'(m[7]) - 18'(m[5]);
      end
      BR_Y: begin
        na_nxt = 18'(m[1]) + 18'(m[3]); nb_nxt = 18'(m[5]) + 18'(m[7]);
        nc_nxt = 18'(m[2]) - 18'(m[6]);
      end
      default: begin
        na_nxt = 18'(m[2]) + 18'(m[6]); nb_nxt = 18'(m[5]) + 18'(m[7]);
        nc_nxt = 18'(m[3]) - 18'(m[1]);
      end
    endcase
  end

  logic                    s1_vld_r;
  branch_t                 s1_br_r;
  logic signed [ARG_W-1:0] s1_arg_r;
  logic signed [17:0]      s1_n_r [3];
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= in_tvalid;
    end
    if (en) begin
      s1_br_r <= br_nxt;
      s1_arg_r <= arg_nxt;
      s1_n_r[0] <= na_nxt;
      s1_n_r[1] <= nb_nxt;
      s1_n_r[2] <= nc_nxt;
    end
  end

  // Square root of arg << FRAC_BITS; bad arguments feed zero.
  logic s1_bad;
  logic [RAD_W-1:0] rad;
  logic [SIDE_W-1:0] sq_side_in, sq_side;
  assign s1_bad = (s1_arg_r <= 0);
  assign rad = s1_bad ? '0 : (RAD_W'(unsigned'(s1_arg_r)) << FRAC_BITS);
  assign sq_side_in = {s1_bad, s1_br_r, s1_n_r[2], s1_n_r[1], s1_n_r[0]};

  logic sq_vld;
  logic [ROOT_W-1:0] root;
  rmq_sqrt #(.IN_W(RAD_W), .SIDE_W(SIDE_W)) u_sqrt (
    .clk, .rst_n, .en, .in_vld(s1_vld_r), .in_rad(rad), .in_side(sq_side_in),
    .out_vld(sq_vld), .out_root(root), .out_side(sq_side)
  );

  // Magnitudes and shifted numerators, ahead of the first divider stage.
  logic signed [17:0] sq_n [3];
  logic [2:0] sq_sgn;
  logic [NUM_W-1:0] dnum [3];
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      sq_n[k] = sq_side[k*18 +: 18];
      sq_sgn[k] = sq_n[k][17];
      dnum[k] = NUM_W'(sq_sgn[k] ? 18'(-sq_n[k]) : 18'(sq_n[k])) << FRAC_BITS;
    end
  end

  logic [DEN_W-1:0] den;
  logic [ROOT_W-1:0] root_safe;
  assign root_safe = (root == '0) ? ROOT_W'(1) : root;
  assign den = {root_safe, 1'b0};

  localparam int DSIDE_W = 3 + 3 + ROOT_W;
  logic [DSIDE_W-1:0] dv_side_in, dv_side;
  assign dv_side_in = {sq_side[56:54], sq_sgn, root};

  logic dv_vld;
  logic [NUM_W-1:0] quo [3];
  rmq_div #(.NUM_W(NUM_W), .DEN_W(DEN_W), .SIDE_W(DSIDE_W)) u_div (
    .clk, .rst_n, .en, .in_vld(sq_vld), .in_num(dnum), .in_den(den),
    .in_side(dv_side_in), .out_vld(dv_vld), .out_quo(quo), .out_side(dv_side)
  );

  // Saturation and component placement.
  localparam logic [NUM_W-1:0] ONE_N = NUM_W'(1) << FRAC_BITS;
  localparam logic [ROOT_W-1:0] ONE_R = ROOT_W'(1) << FRAC_BITS;
  logic [ROOT_W-1:0] dv_root, half_m;
  logic [2:0] dv_sgn;
  logic dv_bad;
  branch_t dv_br;
  logic [Q_W-1:0] qd [3];
  logic [Q_W-1:0] half_q;
  logic [Q_W-1:0] qx_nxt, qy_nxt, qz_nxt, qw_nxt;
  logic [NUM_W-1:0] mg;
  always_comb begin
    dv_root = dv_side[ROOT_W-1:0];
    dv_sgn = dv_side[ROOT_W +: 3];
    dv_br = branch_t'(dv_side[ROOT_W+3 +: 2]);
    dv_bad = dv_side[ROOT_W+5];
    half_m = dv_root >> 1;
    if (half_m > ONE_R) half_m = ONE_R;
    if (half_m > ROOT_W'(32767)) half_m = ROOT_W'(32767);
    half_q = Q_W'(half_m);
    for (int k = 0; k < 3; k++) begin
      mg = quo[k];
      if (mg > ONE_N) mg = ONE_N;
      if (mg > NUM_W'(32767)) mg = NUM_W'(32767);
      qd[k] = dv_sgn[k] ? Q_W'(-Q_W'(mg) - ((Q_W'(mg) == 16'd32767 &&
               ONE_N > NUM_W'(32767)) ? 16'd1 : 16'd0)) : Q_W'(mg);
    end
    unique case (dv_br)
      BR_TRACE: begin qx_nxt = qd[0]; qy_nxt = qd[1]; qz_nxt = qd[2]; qw_nxt = half_q; end
      BR_X:     begin qx_nxt = half_q; qy_nxt = qd[0]; qz_nxt = qd[1]; qw_nxt = qd[2]; end
      BR_Y:     begin qx_nxt = qd[0]; qy_nxt = half_q; qz_nxt = qd[1]; qw_nxt = qd[2]; end
      default:  begin qx_nxt = qd[0]; qy_nxt = qd[1]; qz_nxt = half_q; qw_nxt = qd[2]; end
    endcase
    if (dv_bad) begin
      qx_nxt = '0; qy_nxt = '0; qz_nxt = '0; qw_nxt = '0;
    end
  end

  logic [63:0] out_data_r;
  logic [2:0]  out_user_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= dv_vld;
    end
    if (en) begin
      out_data_r <= {qw_nxt, qz_nxt, qy_nxt, qx_nxt};
      out_user_r <= {dv_bad, dv_br};
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata = out_data_r;
  assign out_tuser = out_user_r;
endmodule

// ----- rtl/rmq_checker.sv -----
// Port-level checker for the rotation matrix to quaternion unit, with bind.
// Depends on assert_macros.svh.
`include "assert_macros.svh"
module rmq_port_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [63:0]  out_tdata,
  input logic [2:0]   out_tuser
);
  `ASSERT_CLK(a_stall_holds, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "stalled beat changed")
  `ASSERT_CLK(a_ready_follows, clk, rst_n, out_tvalid && !out_tready |-> !in_tready, "input taken while output stalled")
  `ASSERT_CLK(a_bad_zero, clk, rst_n, out_tvalid && out_tuser[2] |-> out_tdata == 64'd0, "bad matrix with nonzero components")
  `ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_tvalid, "valid after reset")
endmodule

bind rotation_matrix_to_quaternion_unit rmq_port_checker u_rmq_checker (
  .clk, .rst_n, .in_tready, .out_tvalid, .out_tready, .out_tdata, .out_tuser
);

// ----- sim/rmq_checker.sv -----
// Checker for the rotation matrix to quaternion unit: predicts each output beat
// from the accepted input beats and compares field by field. Depends on rmq_pkg.
module rmq_checker import rmq_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [143:0] in_tdata,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [63:0]  out_tdata,
  input  logic [2:0]   out_tuser,
  output int           errors,
  output int           pending
);
  localparam longint ONE = longint'(1) << FRAC_BITS_DEF;

  typedef struct packed {
    logic [15:0] qx, qy, qz, qw;
    branch_t     branch;
    logic        bad;
  } quat_beat_t;

  quat_beat_t quat_queue[$];

  function automatic longint sat_one(longint v);
    if (v > ONE) v = ONE;
    if (v < -ONE) v = -ONE;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v;
  endfunction

  // Bit-serial floor square root of a nonnegative value.
  function automatic longint floor_root(longint v);
    longint res, b;
    res = 0;
    b = longint'(1) << 62;
    while (b > v) b = b >>> 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v = v - (res + b);
        res = (res >>> 1) + b;
      end else begin
        res = res >>> 1;
      end
      b = b >>> 2;
    end
    return res;
  endfunction

  // (num * ONE) / (2r), truncated toward zero and clamped.
  function automatic longint quot(longint num, longint r);
    longint mag, q;
    mag = (num < 0) ? -num : num;
    q = (mag << FRAC_BITS_DEF) / (2 * r);
    if (q > ONE) q = ONE;
    return sat_one((num < 0) ? -q : q);
  endfunction

  function automatic quat_beat_t matrix_to_quat(logic [143:0] d);
    longint m[9];
    longint tr, arg, r, half;
    longint q[4];
    quat_beat_t res;
    for (int i = 0; i < 9; i++) m[i] = longint'($signed(d[16*i +: 16]));
    tr = m[0] + m[4] + m[8];
    q = '{0, 0, 0, 0};
    res.bad = 1'b0;
    if (tr > 0) begin
      res.branch = BR_TRACE;
      arg = ONE + tr;
    end else if (m[0] > m[4] && m[0] > m[8]) begin
      res.branch = BR_X;
      arg = ONE + m[0] - m[4] - m[8];
    end else if (m[4] > m[8]) begin
      res.branch = BR_Y;
      arg = ONE + m[4] - m[0] - m[8];
    end else begin
      res.branch = BR_Z;
      arg = ONE + m[8] - m[0] - m[4];
    end
    if (arg <= 0) begin
      res.bad = 1'b1;
    end else begin
      r = floor_root(arg << FRAC_BITS_DEF);
      half = sat_one(r >>> 1);
      case (res.branch)
        BR_TRACE: begin
          q[0] = quot(m[7] - m[5], r); q[1] = quot(m[2] - m[6], r);
          q[2] = quot(m[3] - m[1], r); q[3] = half;
        end
        BR_X: begin
          q[0] = half; q[1] = quot(m[1] + m[3], r);
          q[2] = quot(m[2] + m[6], r); q[3] = quot(m[7] - m[5], r);
        end
        BR_Y: begin
          q[0] = quot(m[1] + m[3], r); q[1] = half;
          q[2] = quot(m[5] + m[7], r); q[3] = quot(m[2] - m[6], r);
        end
        default: begin
          q[0] = quot(m[2] + m[6], r); q[1] = quot(m[5] + m[7], r);
          q[2] = half; q[3] = quot(m[3] - m[1], r);
        end
      endcase
    end
    res.qx = q[0][15:0];
    res.qy = q[1][15:0];
    res.qz = q[2][15:0];
    res.qw = q[3][15:0];
    return res;
  endfunction

  quat_beat_t want, got;

  always @(posedge clk) begin
    if (!rst_n) begin
      errors <= 0;
    end else begin
      if (in_tvalid && in_tready) quat_queue.push_back(matrix_to_quat(in_tdata));
      if (out_tvalid && out_tready) begin
        got = {out_tdata[15:0], out_tdata[31:16], out_tdata[47:32], out_tdata[63:48],
               branch_t'(out_tuser[1:0]), out_tuser[2]};
        if (quat_queue.size() == 0) begin
          if (errors < 10) $display("unexpected output beat %h", got);
          errors <= errors + 1;
        end else begin
          want = quat_queue.pop_front();
          if (want !== got) begin
            if (errors < 10)
              $display("mismatch: exp q=%h %h %h %h br=%0d bad=%b got q=%h %h %h %h br=%0d bad=%b",
                       want.qx, want.qy, want.qz, want.qw, want.branch, want.bad,
                       got.qx, got.qy, got.qz, got.qw, got.branch, got.bad);
            errors <= errors + 1;
          end
        end
      end
    end
    pending <= quat_queue.size();
  end
endmodule

// ----- sim/tb_rotation_matrix_to_quaternion_unit.sv -----
// Testbench top for the rotation matrix to quaternion unit: directed and random
// matrices with bursty input and stalling output. Depends on the unit and rmq_checker.
module tb_rotation_matrix_to_quaternion_unit;
  localparam int RANDOM_BEATS = 1630;
  localparam int IDLE_LIMIT = 5000;
  localparam int ONE = 16384;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [143:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [63:0]  out_tdata;
  logic [2:0]   out_tuser;
  int           errors, pending;
  int           idle_cycles = 0;

  always #1 clk = ~clk;

  rotation_matrix_to_quaternion_unit i_dut (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser
  );

  rmq_checker i_checker (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser, .errors, .pending
  );

  // The receiver alternates between runs of full readiness, random stalls and
  // hard stalls, each of random length, so back pressure hits every pipe phase.
  int stall_mode = 0, stall_left = 0;
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_left <= $urandom_range(1, 40);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= ($urandom_range(0, 3) != 0);
      default: out_tready <= 1'b0;
    endcase
  end

  // Any cycle without an accepted beat on either side counts toward timeout.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic logic [143:0] pack_matrix(int e[9]);
    logic [143:0] d;
    for (int i = 0; i < 9; i++) d[16*i +: 16] = e[i][15:0];
    return d;
  endfunction

  // One beat: present it, then hold until the block accepts it. Valid is
  // lowered only when the burst ends, so it never drops between beats.
  task automatic send_beat(logic [143:0] d, bit last_of_burst);
    in_tvalid <= 1'b1;
    in_tdata <= d;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (last_of_burst) in_tvalid <= 1'b0;
  endtask

  // Every burst is followed by an idle gap, so valid is never
  // lowered and raised again at the same edge.
  int burst_left = 0;
  task automatic send_paced(logic [143:0] d);
    int gap;
    if (burst_left == 0) burst_left = $urandom_range(1, 30);
    burst_left--;
    send_beat(d, burst_left == 0);
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(1, 12);
      repeat (gap) @(posedge clk);
    end
  endtask

  // Random matrix: full-range elements, elements within +-ONE, or, for half
  // the draws, a one-axis rotation-like pattern with perturbation; every branch is reached.
  function automatic logic [143:0] rand_matrix();
    int e[9];
    int kind, c, s, a;
    kind = $urandom_range(0, 9);
    if (kind < 3) begin
      for (int i = 0; i < 9; i++) e[i] = $urandom_range(0, 65535) - 32768;
    end else if (kind < 5) begin
      for (int i = 0; i < 9; i++) e[i] = $urandom_range(0, 2 * ONE) - ONE;
    end else begin
      // Signed permutation with a planar rotation: c, s on the chosen plane.
      c = $urandom_range(0, 2 * ONE) - ONE;
      s = $urandom_range(0, 2 * ONE) - ONE;
      a = $urandom_range(0, 2);
      e = '{0, 0, 0, 0, 0, 0, 0, 0, 0};
      case (a)
        0: begin e[0] = ($urandom_range(0,1)) ? ONE : -ONE;
                 e[4] = c; e[5] = -s; e[7] = s; e[8] = c; end
        1: begin e[4] = ($urandom_range(0,1)) ? ONE : -ONE;
                 e[0] = c; e[2] = s; e[6] = -s; e[8] = c; end
        default: begin e[8] = ($urandom_range(0,1)) ? ONE : -ONE;
                 e[0] = c; e[1] = -s; e[3] = s; e[4] = c; end
      endcase
      for (int i = 0; i < 9; i++) e[i] = e[i] + $urandom_range(0, 64) - 32;
    end
    return pack_matrix(e);
  endfunction

  initial begin
    int settle;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: identity, half-turns about each axis, extremes, ties among
    // the diagonal and the zero matrix (branch three).
    send_paced(pack_matrix('{ONE, 0, 0, 0, ONE, 0, 0, 0, ONE}));
    send_paced(pack_matrix('{ONE, 0, 0, 0, -ONE, 0, 0, 0, -ONE}));
    send_paced(pack_matrix('{-ONE, 0, 0, 0, ONE, 0, 0, 0, -ONE}));
    send_paced(pack_matrix('{-ONE, 0, 0, 0, -ONE, 0, 0, 0, ONE}));
    send_paced(pack_matrix('{0, 0, 0, 0, 0, 0, 0, 0, 0}));
    send_paced(pack_matrix('{-32768, 0, 0, 0, -32768, 0, 0, 0, -32768}));
    send_paced(pack_matrix('{32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767}));
    send_paced(pack_matrix('{-32768, -32768, -32768, -32768, -32768, -32768,
                             -32768, -32768, -32768}));
    send_paced(pack_matrix('{0, 32767, -32768, -32768, -ONE, 32767, 32767, -32768, -ONE}));
    send_paced(pack_matrix('{0, 0, 0, 0, -32768, 0, 0, 0, -32768}));
    send_paced(pack_matrix('{-20000, 0, 0, 0, -20000, 0, 0, 0, 32767}));
    send_paced(pack_matrix('{-ONE, 5, 7, 9, -ONE, 11, 13, 15, -ONE}));
    send_paced(pack_matrix('{1, 0, 0, 0, -1, 0, 0, 0, 0}));
    send_paced(pack_matrix('{-1, 100, -100, 200, 0, -200, 300, -300, 1}));
    send_paced(pack_matrix('{0, ONE, 0, ONE, 0, 0, 0, 0, -ONE}));
    send_paced(pack_matrix('{0, -ONE, 0, ONE, 0, 0, 0, 0, ONE}));
    send_paced(pack_matrix('{-30000, 0, 0, 0, 32767, 0, 0, 0, 32767}));
    send_paced(pack_matrix('{-ONE, 32767, 32767, 32767, -ONE, 32767, 32767, 32767, -ONE}));
    send_paced(pack_matrix('{-16000, -32768, 32767, 32767, 16383, -32768, -32768, 32767,
                             -16000}));
    send_paced(pack_matrix('{16383, 1, -1, 2, -16383, 3, -3, 4, 0}));

    for (int n = 0; n < RANDOM_BEATS; n++) send_paced(rand_matrix());
    in_tvalid <= 1'b0;

    // Step past the accepting edge first, so the count includes the last accepted beat.
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    settle = 0;
    while (settle < 200) begin
      @(posedge clk);
      settle++;
    end
    if (errors == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end
endmodule
